// ----- hdl/rrl_pkg.sv -----
// ----------------------------------------------------------------------------
// rrl_pkg: types and constants for the rectangle region lookup
// Beat layouts, table entry layout, op and status codes.
// ----------------------------------------------------------------------------
package rrl_pkg;

   localparam int MAX_SECTORS_DEF = 64;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   localparam logic [3:0] LOC_NORTH = 4'd1;
   localparam logic [3:0] LOC_SOUTH = 4'd2;
   localparam logic [3:0] LOC_EAST  = 4'd4;
   localparam logic [3:0] LOC_WEST  = 4'd8;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] width;
      logic [7:0] height;
      logic [7:0] sample_id;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       hit_stored;
      logic [7:0] sector_sample;
      logic [3:0] sub_location;
   } rsp_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] w;
      logic [7:0] h;
      logic [7:0] sam;
   } entry_type;

   localparam entry_type CATCH_ALL = '{x: 8'd0, y: 8'd0, w: 8'd255, h: 8'd255, sam: 8'd0};

endpackage

// ----- hdl/rect_region_lookup_sublocation.sv -----
// ----------------------------------------------------------------------------
// rect_region_lookup_sublocation: area-sorted rectangle table with point lookup
// Load inserts in area order; query returns the first holding rectangle, or the
// catch-all if none, with its 3x3 sub-location code; clear empties the table.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  req       in    req_valid/req_ready    req_data  (rrl_pkg::req_type)
//  rsp       out   rsp_valid/rsp_ready    rsp_data  (rrl_pkg::rsp_type)
//
//  Load: writes straight into an empty table, else walks down from the top
//  entry; one table entry read and one written per cycle on the table memory.
//  Query: one entry compared per cycle, from entry 0 upward.
//  Clear and zero-area/full loads go straight to the response. One item at a time.
//  Reset empties the table; entry contents are not cleared.
//  A stalled rsp beat holds the block after its work is done.
// ----------------------------------------------------------------------------
module rect_region_lookup_sublocation #(
   parameter int MAX_SECTORS = rrl_pkg::MAX_SECTORS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rrl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rrl_pkg::rsp_type rsp_data
);
   import rrl_pkg::*;

   localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
   localparam int CW = $clog2(MAX_SECTORS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS  = 3'd1;
   localparam logic [2:0] S_PUT  = 3'd2;
   localparam logic [2:0] S_QRY  = 3'd3;
   localparam logic [2:0] S_CODE = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   entry_type sector_table_ff [MAX_SECTORS];
   entry_type rd_ent_ff;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   req_type       item_ff, item_in;
   logic [15:0]   area_ff, area_in;
   entry_type     match_ff, match_in;
   logic          hit_ff, hit_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   logic [CW-1:0] cnt_dec;
   logic [CW-1:0] idx_inc;
   logic [15:0]   req_area;
   logic [15:0]   ent_area;
   logic          ent_holds;
   entry_type     req_ent;
   entry_type     item_ent;
   logic [7:0]    dx, dy;
   logic [9:0]    dx3, dy3;
   logic [3:0]    code;

   assign cnt_dec  = cnt_ff - 1'b1;
   assign idx_inc  = CW'(idx_ff) + CW'(1);
   assign req_area = 16'(req_data.width) * 16'(req_data.height);
   assign ent_area = 16'(rd_ent_ff.w) * 16'(rd_ent_ff.h);
   assign ent_holds = (item_ff.pos_x >= rd_ent_ff.x) && (item_ff.pos_y >= rd_ent_ff.y)
      && ({1'b0, item_ff.pos_x} <= {1'b0, rd_ent_ff.x} + {1'b0, rd_ent_ff.w})
      && ({1'b0, item_ff.pos_y} <= {1'b0, rd_ent_ff.y} + {1'b0, rd_ent_ff.h});

   assign req_ent  = '{x: req_data.pos_x, y: req_data.pos_y, w: req_data.width,
                       h: req_data.height, sam: req_data.sample_id};
   assign item_ent = '{x: item_ff.pos_x, y: item_ff.pos_y, w: item_ff.width,
                       h: item_ff.height, sam: item_ff.sample_id};

   // sub-location against one and two thirds, exact
   assign dx  = item_ff.pos_x - match_ff.x;
   assign dy  = item_ff.pos_y - match_ff.y;
   assign dx3 = {1'b0, dx, 1'b0} + {2'b00, dx};
   assign dy3 = {1'b0, dy, 1'b0} + {2'b00, dy};

   always_comb begin
      code = 4'd0;
      if (dx3 <= {2'b00, match_ff.w}) begin
         code = code | LOC_WEST;
      end else if (dx3 >= {1'b0, match_ff.w, 1'b0}) begin
         code = code | LOC_EAST;
      end
      if (dy3 <= {2'b00, match_ff.h}) begin
         code = code | LOC_NORTH;
      end else if (dy3 >= {1'b0, match_ff.h, 1'b0}) begin
         code = code | LOC_SOUTH;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      item_in      = item_ff;
      area_in      = area_ff;
      match_in     = match_ff;
      hit_in       = hit_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = item_ent;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_valid) begin
               item_in = req_data;
               area_in = req_area;
               res_in  = '0;
               hit_in  = 1'b0;
               state_in = S_DONE;
               case (req_data.op)
                  OP_LOAD: begin
                     rd_addr = cnt_dec[AW-1:0];
                     idx_in  = cnt_dec[AW-1:0];
                     if (req_area == 16'd0) begin
                        res_in.status = ST_ZERO;
                     end else if (cnt_ff >= CW'(MAX_SECTORS)) begin
                        res_in.status = ST_FULL;
                     end else if (cnt_ff == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = req_ent;
                        cnt_in  = cnt_ff + 1'b1;
                     end else begin
                        state_in = S_INS;
                     end
                  end
                  OP_QUERY: begin
                     idx_in = '0;
                     if (cnt_ff == '0) begin
                        match_in = CATCH_ALL;
                        state_in = S_CODE;
                     end else begin
                        state_in = S_QRY;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS: begin
            rd_addr = idx_ff - 1'b1;
            wr_addr = idx_ff + 1'b1;
            if (ent_area > area_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_ent_ff;
               if (idx_ff == '0) begin
                  state_in = S_PUT;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end else begin
               wr_en    = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_DONE;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_DONE;
         end
         S_QRY: begin
            rd_addr = idx_ff + 1'b1;
            if (ent_holds) begin
               match_in = rd_ent_ff;
               hit_in   = 1'b1;
               state_in = S_CODE;
            end else if (idx_inc == cnt_ff) begin
               match_in = CATCH_ALL;
               state_in = S_CODE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CODE: begin
            res_in.status        = ST_OK;
            res_in.hit_stored    = hit_ff;
            res_in.sector_sample = match_ff.sam;
            res_in.sub_location  = code;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sector_table_ff[wr_addr] <= wr_data;
      end
      rd_ent_ff <= sector_table_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      item_ff  <= item_in;
      area_ff  <= area_in;
      match_ff <= match_in;
      hit_ff   <= hit_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_SECTORS))
      else $error("sector count above table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready high right after an accepted beat");

   a_catch_all_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit_stored || rsp_data.sector_sample == 8'd0))
      else $error("catch-all answer with nonzero sample");

   a_code_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!(rsp_data.sub_location[0] && rsp_data.sub_location[1])
                     && !(rsp_data.sub_location[2] && rsp_data.sub_location[3])))
      else $error("sub-location has opposite directions set");

endmodule
